@@ hw/rtl/xds_pkg.sv @@
// ----------------------------------------------------------------------------
// xds_pkg
// shared types and constants of the xor distance shortlist
// ----------------------------------------------------------------------------
`default_nettype none

package xds_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int MARK_DEPTH  = 64;
  localparam int RESULT_CAP  = 64;

  localparam int ID_W    = 256;
  localparam int WORD_W  = 64;
  localparam int HOST_W  = 32;
  localparam int PORT_W  = 16;
  localparam int SSZ_W   = 7;
  localparam int CIDX_W  = 3;

  localparam int TIDX_W  = $clog2(TABLE_DEPTH);
  localparam int MIDX_W  = $clog2(MARK_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int MCNT_W  = $clog2(MARK_DEPTH + 1);
  localparam int PTR_W   = (CNT_W > MCNT_W) ? CNT_W : MCNT_W;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_MARK   = 2'd2,
    KIND_LIST   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_DUP   = 2'd1,
    STS_EVICT = 2'd2,
    STS_FULL  = 2'd3
  } status_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_TGT0 = 3'd0,
    CFG_TGT1 = 3'd1,
    CFG_TGT2 = 3'd2,
    CFG_TGT3 = 3'd3,
    CFG_SSZ  = 3'd4
  } cfg_idx_e;

  localparam logic [SSZ_W-1:0] SSZ_RESET = 7'd20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TSCAN,
    ST_MSCAN,
    ST_ISHIFT,
    ST_PLACE,
    ST_RSHIFT,
    ST_RESP,
    ST_LRD,
    ST_LOUT
  } state_e;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [HOST_W-1:0] host;
    logic [ID_W-1:0]   xdist;
    logic [ID_W-1:0]   id;
  } tent_t;

  typedef struct packed {
    logic [ID_W-1:0]  target;
    logic [SSZ_W-1:0] ssz;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/xds_ram.sv @@
// ----------------------------------------------------------------------------
// xds_ram
// simple dual port memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module xds_ram #(
  parameter int W = 8,
  parameter int D = 64,
  localparam int AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wa,
  input  wire logic [W-1:0]  wd,
  input  wire logic          re,
  input  wire logic [AW-1:0] ra,
  output logic      [W-1:0]  rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/xds_engine.sv @@
// ----------------------------------------------------------------------------
// xds_engine
// sequencer over the contact table and the marked set, with result register
// ----------------------------------------------------------------------------
`default_nettype none

module xds_engine (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire xds_pkg::cfg_t              cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_kind,
  input  wire logic [xds_pkg::ID_W-1:0]   in_id,
  input  wire logic [xds_pkg::HOST_W-1:0] in_host,
  input  wire logic [xds_pkg::PORT_W-1:0] in_port,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic                            out_has_entry,
  output logic [xds_pkg::ID_W-1:0]        out_id,
  output logic [xds_pkg::HOST_W-1:0]      out_host,
  output logic [xds_pkg::PORT_W-1:0]      out_port,
  output logic                            out_is_last,
  output logic                            out_search_done
);

  import xds_pkg::*;

  state_e               st_r, st_nxt;
  kind_e                kind_r, kind_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [ID_W-1:0]      dist_r, dist_nxt;
  logic [HOST_W-1:0]    host_r, host_nxt;
  logic [PORT_W-1:0]    port_r, port_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [MCNT_W-1:0]    mcnt_r, mcnt_nxt;
  logic [TABLE_DEPTH-1:0] mk_r, mk_nxt;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic [PTR_W-1:0]     rem_r, rem_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic [PTR_W-1:0]     chk_i_r, chk_i_nxt;
  logic                 found_r, found_nxt;
  logic [PTR_W-1:0]     fidx_r, fidx_nxt;
  logic                 posf_r, posf_nxt;
  logic [PTR_W-1:0]     pos_r, pos_nxt;
  logic                 mdup_r, mdup_nxt;
  status_e              sts_r, sts_nxt;
  logic                 wv_r, wv_nxt;
  logic [TIDX_W-1:0]    wa_r, wa_nxt;
  logic                 emit_r, emit_nxt;

  logic                 o_valid_r, o_valid_nxt;
  logic [1:0]           o_status_r, o_status_nxt;
  logic                 o_has_r, o_has_nxt;
  logic [ID_W-1:0]      o_id_r, o_id_nxt;
  logic [HOST_W-1:0]    o_host_r, o_host_nxt;
  logic [PORT_W-1:0]    o_port_r, o_port_nxt;
  logic                 o_last_r, o_last_nxt;
  logic                 o_done_r, o_done_nxt;

  logic                 t_we, t_re;
  logic [TIDX_W-1:0]    t_wa, t_ra;
  tent_t                t_wd, t_rd;
  logic                 m_we, m_re;
  logic [MIDX_W-1:0]    m_wa, m_ra;
  logic [ID_W-1:0]      m_wd, m_rd;

  logic                 slot_free;
  logic [TABLE_DEPTH-1:0] inwin;
  logic [TABLE_DEPTH-1:0] above;
  logic                 sdone;
  logic                 more_after;
  logic [PTR_W-1:0]     ceff;

  xds_ram #(.W($bits(tent_t)), .D(TABLE_DEPTH)) u_tbl (
    .clk(clk), .we(t_we), .wa(t_wa), .wd(t_wd),
    .re(t_re), .ra(t_ra), .rd(t_rd)
  );

  xds_ram #(.W(ID_W), .D(MARK_DEPTH)) u_mrk (
    .clk(clk), .we(m_we), .wa(m_wa), .wd(m_wd),
    .re(m_re), .ra(m_ra), .rd(m_rd)
  );

  assign slot_free = !o_valid_r || out_ready;
  assign in_ready  = (st_r == ST_IDLE);

  // window and marked flag summaries
  always_comb begin
    int win;
    win = int'(cnt_r);
    if (int'(cfg.ssz) < win) begin
      win = int'(cfg.ssz);
    end
    if (RESULT_CAP < win) begin
      win = RESULT_CAP;
    end
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      inwin[j] = (j < win);
      above[j] = (j > int'(ptr_r));
    end
    sdone      = ~|(inwin & ~mk_r);
    more_after = |(inwin & above & ~mk_r);
  end

  always_comb begin
    st_nxt       = st_r;
    kind_nxt     = kind_r;
    id_nxt       = id_r;
    dist_nxt     = dist_r;
    host_nxt     = host_r;
    port_nxt     = port_r;
    cnt_nxt      = cnt_r;
    mcnt_nxt     = mcnt_r;
    mk_nxt       = mk_r;
    ptr_nxt      = ptr_r;
    rem_nxt      = rem_r;
    chk_v_nxt    = 1'b0;
    chk_i_nxt    = chk_i_r;
    found_nxt    = found_r;
    fidx_nxt     = fidx_r;
    posf_nxt     = posf_r;
    pos_nxt      = pos_r;
    mdup_nxt     = mdup_r;
    sts_nxt      = sts_r;
    wv_nxt       = 1'b0;
    wa_nxt       = wa_r;
    emit_nxt     = emit_r;
    o_valid_nxt  = o_valid_r && !out_ready;
    o_status_nxt = o_status_r;
    o_has_nxt    = o_has_r;
    o_id_nxt     = o_id_r;
    o_host_nxt   = o_host_r;
    o_port_nxt   = o_port_r;
    o_last_nxt   = o_last_r;
    o_done_nxt   = o_done_r;
    t_we = 1'b0; t_wa = wa_r; t_wd = t_rd;
    t_re = 1'b0; t_ra = ptr_r[TIDX_W-1:0];
    m_we = 1'b0; m_wa = mcnt_r[MIDX_W-1:0]; m_wd = id_r;
    m_re = 1'b0; m_ra = ptr_r[MIDX_W-1:0];
    ceff = cnt_r;
    if (cnt_r >= CNT_W'(TABLE_DEPTH)) begin
      ceff = PTR_W'(TABLE_DEPTH - 1);
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = kind_e'(in_kind);
          id_nxt    = in_id;
          dist_nxt  = in_id ^ cfg.target;
          host_nxt  = in_host;
          port_nxt  = in_port;
          ptr_nxt   = '0;
          found_nxt = 1'b0;
          posf_nxt  = 1'b0;
          pos_nxt   = PTR_W'(cnt_r);
          mdup_nxt  = 1'b0;
          emit_nxt  = 1'b0;
          st_nxt    = (kind_e'(in_kind) == KIND_LIST) ? ST_LRD : ST_TSCAN;
        end
      end

      ST_TSCAN: begin
        if (ptr_r < PTR_W'(cnt_r)) begin
          t_re      = 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
          chk_v_nxt = 1'b1;
          chk_i_nxt = ptr_r;
        end
        if (chk_v_r) begin
          if (t_rd.id == id_r && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt  = chk_i_r;
          end
          if (!posf_r && t_rd.xdist > dist_r) begin
            posf_nxt = 1'b1;
            pos_nxt  = chk_i_r;
          end
        end
        if (!(ptr_r < PTR_W'(cnt_r)) && !chk_v_r) begin
          ptr_nxt = '0;
          case (kind_r)
            KIND_PUSH: begin
              if (found_r) begin
                sts_nxt = STS_DUP;
                st_nxt  = ST_RESP;
              end else begin
                st_nxt = ST_MSCAN;
              end
            end
            KIND_REMOVE: begin
              if (found_r) begin
                ptr_nxt = fidx_r + 1'b1;
                rem_nxt = PTR_W'(cnt_r) - 1'b1 - fidx_r;
                sts_nxt = STS_DONE;
                st_nxt  = ST_RSHIFT;
              end else begin
                sts_nxt = STS_DUP;
                st_nxt  = ST_RESP;
              end
            end
            default: st_nxt = ST_MSCAN;
          endcase
        end
      end

      ST_MSCAN: begin
        if (ptr_r < PTR_W'(mcnt_r)) begin
          m_re      = 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
          chk_v_nxt = 1'b1;
        end
        if (chk_v_r && m_rd == id_r) begin
          mdup_nxt = 1'b1;
        end
        if (!(ptr_r < PTR_W'(mcnt_r)) && !chk_v_r) begin
          if (kind_r == KIND_PUSH) begin
            if (cnt_r >= CNT_W'(TABLE_DEPTH) && pos_r >= PTR_W'(TABLE_DEPTH)) begin
              sts_nxt = STS_FULL;
              st_nxt  = ST_RESP;
            end else begin
              sts_nxt = (cnt_r >= CNT_W'(TABLE_DEPTH)) ? STS_EVICT : STS_DONE;
              cnt_nxt = CNT_W'(ceff);
              rem_nxt = ceff - pos_r;
              ptr_nxt = ceff - 1'b1;
              st_nxt  = ST_ISHIFT;
            end
          end else begin
            if (mdup_r) begin
              sts_nxt = STS_DUP;
            end else if (mcnt_r >= MCNT_W'(MARK_DEPTH)) begin
              sts_nxt = STS_FULL;
            end else begin
              m_we     = 1'b1;
              mcnt_nxt = mcnt_r + 1'b1;
              if (found_r) begin
                mk_nxt[fidx_r[TIDX_W-1:0]] = 1'b1;
              end
              sts_nxt = STS_DONE;
            end
            st_nxt = ST_RESP;
          end
        end
      end

      ST_ISHIFT: begin
        if (rem_r != '0) begin
          t_re    = 1'b1;
          ptr_nxt = ptr_r - 1'b1;
          rem_nxt = rem_r - 1'b1;
          wv_nxt  = 1'b1;
          wa_nxt  = TIDX_W'(ptr_r + 1'b1);
        end
        if (wv_r) begin
          t_we = 1'b1;
        end
        if (rem_r == '0 && !wv_r) begin
          st_nxt = ST_PLACE;
        end
      end

      ST_PLACE: begin
        t_we = 1'b1;
        t_wa = pos_r[TIDX_W-1:0];
        t_wd = '{port: port_r, host: host_r, xdist: dist_r, id: id_r};
        for (int j = 0; j < TABLE_DEPTH; j++) begin
          if (j == int'(pos_r)) begin
            mk_nxt[j] = mdup_r;
          end else if (j > int'(pos_r)) begin
            mk_nxt[j] = mk_r[(j > 0) ? j - 1 : 0];
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        st_nxt  = ST_RESP;
      end

      ST_RSHIFT: begin
        if (rem_r != '0) begin
          t_re    = 1'b1;
          ptr_nxt = ptr_r + 1'b1;
          rem_nxt = rem_r - 1'b1;
          wv_nxt  = 1'b1;
          wa_nxt  = TIDX_W'(ptr_r - 1'b1);
        end
        if (wv_r) begin
          t_we = 1'b1;
        end
        if (rem_r == '0 && !wv_r) begin
          for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (j >= int'(fidx_r)) begin
              mk_nxt[j] = (j + 1 < TABLE_DEPTH) ? mk_r[(j + 1) % TABLE_DEPTH] : 1'b0;
            end
          end
          cnt_nxt = cnt_r - 1'b1;
          st_nxt  = ST_RESP;
        end
      end

      ST_RESP: begin
        if (slot_free) begin
          o_valid_nxt  = 1'b1;
          o_status_nxt = sts_r;
          o_has_nxt    = 1'b0;
          o_id_nxt     = '0;
          o_host_nxt   = '0;
          o_port_nxt   = '0;
          o_last_nxt   = 1'b1;
          o_done_nxt   = sdone;
          st_nxt       = ST_IDLE;
        end
      end

      ST_LRD: begin
        if (ptr_r >= PTR_W'(TABLE_DEPTH) || !inwin[ptr_r[TIDX_W-1:0]]) begin
          if (emit_r) begin
            st_nxt = ST_IDLE;
          end else if (slot_free) begin
            o_valid_nxt  = 1'b1;
            o_status_nxt = STS_DONE;
            o_has_nxt    = 1'b0;
            o_id_nxt     = '0;
            o_host_nxt   = '0;
            o_port_nxt   = '0;
            o_last_nxt   = 1'b1;
            o_done_nxt   = 1'b1;
            st_nxt       = ST_IDLE;
          end
        end else if (mk_r[ptr_r[TIDX_W-1:0]]) begin
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          t_re   = 1'b1;
          st_nxt = ST_LOUT;
        end
      end

      ST_LOUT: begin
        if (slot_free) begin
          o_valid_nxt  = 1'b1;
          o_status_nxt = STS_DONE;
          o_has_nxt    = 1'b1;
          o_id_nxt     = t_rd.id;
          o_host_nxt   = t_rd.host;
          o_port_nxt   = t_rd.port;
          o_last_nxt   = !more_after;
          o_done_nxt   = 1'b0;
          ptr_nxt      = ptr_r + 1'b1;
          emit_nxt     = 1'b1;
          st_nxt       = ST_LRD;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cnt_r     <= '0;
      mcnt_r    <= '0;
      mk_r      <= '0;
      chk_v_r   <= 1'b0;
      wv_r      <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      mcnt_r    <= mcnt_nxt;
      mk_r      <= mk_nxt;
      chk_v_r   <= chk_v_nxt;
      wv_r      <= wv_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    id_r       <= id_nxt;
    dist_r     <= dist_nxt;
    host_r     <= host_nxt;
    port_r     <= port_nxt;
    ptr_r      <= ptr_nxt;
    rem_r      <= rem_nxt;
    chk_i_r    <= chk_i_nxt;
    found_r    <= found_nxt;
    fidx_r     <= fidx_nxt;
    posf_r     <= posf_nxt;
    pos_r      <= pos_nxt;
    mdup_r     <= mdup_nxt;
    sts_r      <= sts_nxt;
    wa_r       <= wa_nxt;
    emit_r     <= emit_nxt;
    o_status_r <= o_status_nxt;
    o_has_r    <= o_has_nxt;
    o_id_r     <= o_id_nxt;
    o_host_r   <= o_host_nxt;
    o_port_r   <= o_port_nxt;
    o_last_r   <= o_last_nxt;
    o_done_r   <= o_done_nxt;
  end

  assign out_valid       = o_valid_r;
  assign out_status      = o_status_r;
  assign out_has_entry   = o_has_r;
  assign out_id          = o_id_r;
  assign out_host        = o_host_r;
  assign out_port        = o_port_r;
  assign out_is_last     = o_last_r;
  assign out_search_done = o_done_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH) && mcnt_r <= MCNT_W'(MARK_DEPTH))
    else $error("store count beyond depth");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (!chk_v_r && !wv_r))
    else $error("memory pipeline busy while idle");

  a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_PLACE) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not grow the table");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid) && out_status == STS_EVICT) |->
    cnt_r == CNT_W'(TABLE_DEPTH))
    else $error("eviction reported with table not full");

endmodule

`default_nettype wire

@@ hw/rtl/xor_distance_sorted_shortlist.sv @@
// ----------------------------------------------------------------------------
// xor_distance_sorted_shortlist
// contact table sorted by xor distance to a target, with a marked id set
// ----------------------------------------------------------------------------
// push: scans the table and the marked set, then shifts entries; remove: scans
//   the table, then shifts entries down; mark: scans the table and the marked set
// list: walks the window, skips marked entries and emits the others in order
// one item at a time; the next item is taken while a result waits at the output
// reset: synchronous, clears both fill counts and the mark flags; no clearing pass
`default_nettype none

module xor_distance_sorted_shortlist (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [xds_pkg::CIDX_W-1:0]      cfg_index,
  input  wire logic [xds_pkg::WORD_W-1:0]      cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_kind,
  input  wire logic [xds_pkg::WORD_W-1:0]      in_id_w0,
  input  wire logic [xds_pkg::WORD_W-1:0]      in_id_w1,
  input  wire logic [xds_pkg::WORD_W-1:0]      in_id_w2,
  input  wire logic [xds_pkg::WORD_W-1:0]      in_id_w3,
  input  wire logic [xds_pkg::HOST_W-1:0]      in_contact_host,
  input  wire logic [xds_pkg::PORT_W-1:0]      in_contact_port,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_status,
  output logic                                 out_has_entry,
  output logic [xds_pkg::WORD_W-1:0]           out_entry_id_w0,
  output logic [xds_pkg::WORD_W-1:0]           out_entry_id_w1,
  output logic [xds_pkg::WORD_W-1:0]           out_entry_id_w2,
  output logic [xds_pkg::WORD_W-1:0]           out_entry_id_w3,
  output logic [xds_pkg::HOST_W-1:0]           out_entry_host,
  output logic [xds_pkg::PORT_W-1:0]           out_entry_port,
  output logic                                 out_is_last,
  output logic                                 out_search_done
);

  import xds_pkg::*;

  logic [3:0][WORD_W-1:0] tgt_r;
  logic [SSZ_W-1:0]       ssz_r;
  cfg_t                   cfg;
  logic [ID_W-1:0]        ent_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
      ssz_r <= SSZ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_TGT0: tgt_r[0] <= cfg_wdata;
        CFG_TGT1: tgt_r[1] <= cfg_wdata;
        CFG_TGT2: tgt_r[2] <= cfg_wdata;
        CFG_TGT3: tgt_r[3] <= cfg_wdata;
        CFG_SSZ:  ssz_r    <= cfg_wdata[SSZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.target = tgt_r;
  assign cfg.ssz    = ssz_r;

  xds_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_id          ({in_id_w3, in_id_w2, in_id_w1, in_id_w0}),
    .in_host        (in_contact_host),
    .in_port        (in_contact_port),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_has_entry  (out_has_entry),
    .out_id         (ent_id),
    .out_host       (out_entry_host),
    .out_port       (out_entry_port),
    .out_is_last    (out_is_last),
    .out_search_done(out_search_done)
  );

  assign out_entry_id_w0 = ent_id[WORD_W-1:0];
  assign out_entry_id_w1 = ent_id[2*WORD_W-1:WORD_W];
  assign out_entry_id_w2 = ent_id[3*WORD_W-1:2*WORD_W];
  assign out_entry_id_w3 = ent_id[4*WORD_W-1:3*WORD_W];

endmodule

`default_nettype wire
